// ===== src/q2e_pkg.sv =====
// Shared types, constants and tables for the quaternion to Euler/gravity block.
// Used by q2e_ctrl, q2e_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
package q2e_pkg;

	localparam int QW = 16;

	// configuration register indexes
	localparam logic [1:0] REG_ROLL  = 2'd0;
	localparam logic [1:0] REG_PITCH = 2'd1;
	localparam logic [1:0] REG_YAW   = 2'd2;

	// product codes for the shared multiplier
	localparam logic [3:0] P_II = 4'd0;
	localparam logic [3:0] P_JJ = 4'd1;
	localparam logic [3:0] P_KK = 4'd2;
	localparam logic [3:0] P_RR = 4'd3;
	localparam logic [3:0] P_IJ = 4'd4;
	localparam logic [3:0] P_RK = 4'd5;
	localparam logic [3:0] P_IK = 4'd6;
	localparam logic [3:0] P_RJ = 4'd7;
	localparam logic [3:0] P_JK = 4'd8;
	localparam logic [3:0] P_RI = 4'd9;

	// operand codes
	localparam logic [1:0] OP_I = 2'd0;
	localparam logic [1:0] OP_J = 2'd1;
	localparam logic [1:0] OP_K = 2'd2;
	localparam logic [1:0] OP_R = 2'd3;

	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [17:0] PI_Q13      = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
	localparam logic signed [32:0] DEG_MUL     = 33'sd58671;
	localparam logic signed [16:0] DEG_LIM     = 17'sd23040;
	localparam logic signed [17:0] ONE_Q14     = 18'sd16384;

	typedef struct packed {
		logic [1:0] a_sel;
		logic [1:0] b_sel;
		logic       neg;
	} mul_op_t;

	typedef struct packed {
		logic       load_in;
		logic       mul_en;
		logic       mul_to_s;
		logic       mul_clr;
		logic [3:0] mul_sel;
		logic       div_load;
		logic       div_step;
		logic       term_store;
		logic [2:0] term_idx;
		logic       cor_load;
		logic       cor_step;
		logic [3:0] cor_k;
		logic [1:0] ang_idx;
		logic       fin_wrap;
		logic       fin_store;
		logic       out_load;
		logic       upd;
	} cmd_t;

	typedef struct packed {
		logic s_zero;
		logic out_free;
	} sts_t;

	function automatic mul_op_t mul_ops(input logic [3:0] sel);
		mul_op_t o;
		o = '{a_sel: OP_I, b_sel: OP_I, neg: 1'b0};
		case (sel)
			P_II: o = '{a_sel: OP_I, b_sel: OP_I, neg: 1'b0};
			P_JJ: o = '{a_sel: OP_J, b_sel: OP_J, neg: 1'b0};
			P_KK: o = '{a_sel: OP_K, b_sel: OP_K, neg: 1'b0};
			P_RR: o = '{a_sel: OP_R, b_sel: OP_R, neg: 1'b0};
			P_IJ: o = '{a_sel: OP_I, b_sel: OP_J, neg: 1'b0};
			P_RK: o = '{a_sel: OP_R, b_sel: OP_K, neg: 1'b0};
			P_IK: o = '{a_sel: OP_I, b_sel: OP_K, neg: 1'b0};
			P_RJ: o = '{a_sel: OP_R, b_sel: OP_J, neg: 1'b1};
			P_JK: o = '{a_sel: OP_J, b_sel: OP_K, neg: 1'b0};
			P_RI: o = '{a_sel: OP_R, b_sel: OP_I, neg: 1'b0};
			default: o = '{a_sel: OP_I, b_sel: OP_I, neg: 1'b0};
		endcase
		return o;
	endfunction

	// two products that make up each matrix term
	function automatic logic [3:0] term_prod(input logic [2:0] t, input logic second);
		logic [3:0] p;
		p = P_II;
		case (t)
			3'd0: p = second ? P_II : P_RR;
			3'd1: p = second ? P_RK : P_IJ;
			3'd2: p = second ? P_RJ : P_IK;
			3'd3: p = second ? P_RI : P_JK;
			3'd4: p = second ? P_KK : P_RR;
			default: p = P_II;
		endcase
		return p;
	endfunction

	// arctangent table, Q0.16 radians
	function automatic logic [15:0] atan_tab(input logic [3:0] k);
		logic [15:0] v;
		v = 16'd0;
		case (k)
			4'd0:  v = 16'd51472;
			4'd1:  v = 16'd30386;
			4'd2:  v = 16'd16055;
			4'd3:  v = 16'd8150;
			4'd4:  v = 16'd4091;
			4'd5:  v = 16'd2047;
			4'd6:  v = 16'd1024;
			4'd7:  v = 16'd512;
			4'd8:  v = 16'd256;
			4'd9:  v = 16'd128;
			4'd10: v = 16'd64;
			4'd11: v = 16'd32;
			4'd12: v = 16'd16;
			4'd13: v = 16'd8;
			4'd14: v = 16'd4;
			4'd15: v = 16'd2;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/q2e_ctrl.sv =====
// Sequencer for the quaternion conversion: steps the shared multiplier,
// divider and CORDIC unit of q2e_datapath. Depends on q2e_pkg.
`timescale 1ns / 1ps
module q2e_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  q2e_pkg::sts_t   sts,
	output q2e_pkg::cmd_t   cmd
);
	import q2e_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SUM  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_DIVL = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_TST  = 4'd6;
	localparam logic [3:0] ST_CORL = 4'd7;
	localparam logic [3:0] ST_COR  = 4'd8;
	localparam logic [3:0] ST_FIN1 = 4'd9;
	localparam logic [3:0] ST_FIN2 = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	logic [3:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [2:0] idx_q, idx_d;
	logic       upd_q, upd_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 5'd1;
		idx_d   = idx_q;
		upd_d   = upd_q;
		cmd     = '0;
		cmd.term_idx = idx_q;
		cmd.ang_idx  = idx_q[1:0];
		cmd.cor_k    = cnt_q[3:0];
		case (state_q)
			ST_IDLE: begin
				cnt_d = 5'd0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_to_s = 1'b1;
				cmd.mul_clr  = (cnt_q == 5'd0);
				cmd.mul_sel  = cnt_q[3:0];
				if (cnt_q == 5'd3) state_d = ST_CHK;
			end
			ST_CHK: begin
				cnt_d = 5'd0;
				idx_d = 3'd0;
				if (sts.s_zero) begin
					upd_d = 1'b0;
					state_d = ST_OUT;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_clr = (cnt_q == 5'd0);
				cmd.mul_sel = term_prod(idx_q, cnt_q[0]);
				if (cnt_q == 5'd1) state_d = ST_DIVL;
			end
			ST_DIVL: begin
				cmd.div_load = 1'b1;
				cnt_d = 5'd0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 5'd16) state_d = ST_TST;
			end
			ST_TST: begin
				cmd.term_store = 1'b1;
				cnt_d = 5'd0;
				if (idx_q == 3'd4) begin
					idx_d = 3'd0;
					state_d = ST_CORL;
				end else begin
					idx_d = idx_q + 3'd1;
					state_d = ST_MUL;
				end
			end
			ST_CORL: begin
				cmd.cor_load = 1'b1;
				cnt_d = 5'd0;
				state_d = ST_COR;
			end
			ST_COR: begin
				cmd.cor_step = 1'b1;
				if (cnt_q == 5'd15) state_d = ST_FIN1;
			end
			ST_FIN1: begin
				cmd.fin_wrap = 1'b1;
				state_d = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.fin_store = 1'b1;
				if (idx_q == 3'd2) begin
					upd_d = 1'b1;
					state_d = ST_OUT;
				end else begin
					idx_d = idx_q + 3'd1;
					state_d = ST_CORL;
				end
			end
			ST_OUT: begin
				cmd.upd = upd_q;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 5'd0;
			idx_q   <= 3'd0;
			upd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			upd_q   <= upd_d;
		end
	end

endmodule

// ===== src/q2e_datapath.sv =====
// Datapath: multiply-accumulate, restoring divider, CORDIC atan2, angle
// finishing, held results and output register. Depends on q2e_pkg.
`timescale 1ns / 1ps
module q2e_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  q2e_pkg::cmd_t        cmd,
	output q2e_pkg::sts_t        sts,
	input  logic signed [15:0]   quat_i,
	input  logic signed [15:0]   quat_j,
	input  logic signed [15:0]   quat_k,
	input  logic signed [15:0]   quat_real,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   roll_deg,
	output logic signed [15:0]   pitch_deg,
	output logic signed [15:0]   yaw_deg,
	output logic signed [15:0]   grav_x,
	output logic signed [15:0]   grav_y,
	output logic signed [15:0]   grav_z,
	output logic                 updated
);
	import q2e_pkg::*;

	logic signed [15:0] q_q [4];
	logic signed [15:0] off_q [3];
	logic signed [15:0] held_ang_q [3];
	logic signed [15:0] held_g_q [3];
	logic signed [15:0] c_q [5];
	logic        [32:0] s_q;
	logic signed [33:0] p_q;
	logic        [32:0] rem_q;
	logic        [16:0] nlo_q;
	logic        [16:0] quo_q;
	logic               neg_q;
	logic signed [27:0] x_q, y_q;
	logic signed [19:0] z_q;
	logic               cz_q;
	logic signed [15:0] a_q;
	logic               out_valid_q;

	// multiplier
	mul_op_t            mop;
	logic signed [15:0] opa, opb;
	logic signed [31:0] prod;
	logic signed [33:0] prod34;

	assign mop    = mul_ops(cmd.mul_sel);
	assign opa    = q_q[mop.a_sel];
	assign opb    = q_q[mop.b_sel];
	assign prod   = opa * opb;
	assign prod34 = {{2{prod[31]}}, prod};

	// divider
	logic        [33:0] mag;
	logic        [48:0] num;
	logic        [33:0] trial;
	logic               fits;

	assign mag   = p_q[33] ? 34'(-p_q) : 34'(p_q);
	assign num   = {mag[32:0], 15'd0} + {17'd0, s_q[32:1]};
	assign trial = {rem_q, nlo_q[16]};
	assign fits  = (trial >= {1'b0, s_q});

	// term finish
	logic signed [17:0] tv, tm;
	logic signed [15:0] c_new;

	always_comb begin
		tv = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		tm = (cmd.term_idx == 3'd0 || cmd.term_idx == 3'd4) ? tv - ONE_Q14 : tv;
		if (tm > ONE_Q14)       c_new = 16'sd16384;
		else if (tm < -ONE_Q14) c_new = -16'sd16384;
		else                    c_new = tm[15:0];
	end

	// CORDIC
	logic signed [16:0] cy, cx;
	logic signed [27:0] x0, y0, xs, ys;
	logic        [15:0] at;

	always_comb begin
		case (cmd.ang_idx)
			2'd0:    begin cy = -17'(c_q[2]); cx = 17'(c_q[4]); end
			2'd1:    begin cy = -17'(c_q[3]); cx = 17'(c_q[4]); end
			default: begin cy = 17'(c_q[1]);  cx = -17'(c_q[0]); end
		endcase
		x0 = {{3{cx[16]}}, cx, 8'd0};
		y0 = {{3{cy[16]}}, cy, 8'd0};
		xs = x_q >>> cmd.cor_k;
		ys = y_q >>> cmd.cor_k;
	end
	assign at = atan_tab(cmd.cor_k);

	// angle finish
	logic signed [19:0] zr;
	logic signed [16:0] ang;
	logic signed [17:0] asum, awrap;
	logic signed [32:0] a33, dm, dr;
	logic signed [15:0] deg;

	always_comb begin
		zr   = z_q + 20'sd4;
		ang  = cz_q ? 17'sd0 : zr[19:3];
		asum = {ang[16], ang} + {{2{off_q[cmd.ang_idx][15]}}, off_q[cmd.ang_idx]};
		awrap = asum;
		if (awrap > PI_Q13)  awrap = awrap - TWO_PI_Q13;
		if (awrap < -PI_Q13) awrap = awrap + TWO_PI_Q13;
		a33 = {{17{a_q[15]}}, a_q};
		dm  = a33 * DEG_MUL;
		dr  = (dm + 33'sd32768) >>> 16;
		if (dr > 33'(DEG_LIM))       deg = 16'sd23040;
		else if (dr < -33'(DEG_LIM)) deg = -16'sd23040;
		else                         deg = dr[15:0];
	end

	assign sts.s_zero   = (s_q == 33'd0);
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int n = 0; n < 3; n++) begin
				off_q[n]      <= '0;
				held_ang_q[n] <= '0;
				held_g_q[n]   <= '0;
			end
		end else begin
			if (cmd.out_load)               out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROLL:  off_q[0] <= cfg_data;
					REG_PITCH: off_q[1] <= cfg_data;
					REG_YAW:   off_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.fin_store) begin
				held_ang_q[cmd.ang_idx] <= deg;
				if (cmd.ang_idx == REG_YAW) begin
					held_g_q[0] <= c_q[2];
					held_g_q[1] <= c_q[3];
					held_g_q[2] <= c_q[4];
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			q_q[OP_I] <= quat_i;
			q_q[OP_J] <= quat_j;
			q_q[OP_K] <= quat_k;
			q_q[OP_R] <= quat_real;
		end
		if (cmd.mul_en) begin
			if (cmd.mul_to_s)
				s_q <= (cmd.mul_clr ? 33'd0 : s_q) + {1'b0, prod[31:0]};
			else
				p_q <= (cmd.mul_clr ? 34'sd0 : p_q) + (mop.neg ? -prod34 : prod34);
		end
		if (cmd.div_load) begin
			rem_q <= {1'b0, num[48:17]};
			nlo_q <= num[16:0];
			quo_q <= '0;
			neg_q <= p_q[33];
		end else if (cmd.div_step) begin
			rem_q <= fits ? 33'(trial - {1'b0, s_q}) : trial[32:0];
			nlo_q <= {nlo_q[15:0], 1'b0};
			quo_q <= {quo_q[15:0], fits};
		end
		if (cmd.term_store) c_q[cmd.term_idx] <= c_new;
		if (cmd.cor_load) begin
			cz_q <= (cx == 17'sd0) && (cy == 17'sd0);
			if (x0 < 0) begin
				if (y0 >= 0) begin
					x_q <= y0; y_q <= -x0; z_q <= HALF_PI_Q16;
				end else begin
					x_q <= -y0; y_q <= x0; z_q <= -HALF_PI_Q16;
				end
			end else begin
				x_q <= x0; y_q <= y0; z_q <= 20'sd0;
			end
		end else if (cmd.cor_step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + $signed({4'd0, at});
			end else begin
				x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - $signed({4'd0, at});
			end
		end
		if (cmd.fin_wrap) a_q <= awrap[15:0];
		if (cmd.out_load) begin
			roll_deg  <= held_ang_q[0];
			pitch_deg <= held_ang_q[1];
			yaw_deg   <= held_ang_q[2];
			grav_x    <= held_g_q[0];
			grav_y    <= held_g_q[1];
			grav_z    <= held_g_q[2];
			updated   <= cmd.upd;
		end
	end

endmodule

// ===== src/quaternion_to_euler_gravity_top.sv =====
// A normal sample runs the squares of i, j, k and real and a zero check, then 5 terms of 2
// multiplies + divider load + 17 divider steps + store, then 3 angles of load + 16 CORDIC steps
// + wrap + store, then the output load. A zero-norm sample skips straight to the output load.
// A new sample is not taken while one is in progress; the next input transaction is
// taken once the result is in the output register, and a stalled result holds that back.
// Reset (arst_n low, asynchronous): offsets, held angles and gravity clear.
`timescale 1ns / 1ps
module quaternion_to_euler_gravity_top (
	input  logic               clk,
	input  logic               arst_n,
	// input channel: one quaternion sample per transaction
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] quat_i,
	input  logic signed [15:0] quat_j,
	input  logic signed [15:0] quat_k,
	input  logic signed [15:0] quat_real,
	// configuration write port, offsets in Q2.13 radians
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// output channel: angles in 1/128 degree, gravity in Q14
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] roll_deg,
	output logic signed [15:0] pitch_deg,
	output logic signed [15:0] yaw_deg,
	output logic signed [15:0] grav_x,
	output logic signed [15:0] grav_y,
	output logic signed [15:0] grav_z,
	output logic               updated
);
	import q2e_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: holds in_stall high for the whole of a sample
	q2e_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, held state and the output register
	q2e_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.quat_i    (quat_i),
		.quat_j    (quat_j),
		.quat_k    (quat_k),
		.quat_real (quat_real),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.roll_deg  (roll_deg),
		.pitch_deg (pitch_deg),
		.yaw_deg   (yaw_deg),
		.grav_x    (grav_x),
		.grav_y    (grav_y),
		.grav_z    (grav_z),
		.updated   (updated)
	);

endmodule
